// ----- hdl/tfc_pkg.sv -----
`default_nettype none

package tfc_pkg;

  // Frame layout
  localparam int FRAME_LAST  = 21;
  localparam int STORE_BYTES = 20;
  localparam int SUM_BYTES   = 18;
  localparam int STOP1_POS   = 20;
  localparam int CSUM_LOW    = 18;
  localparam int CSUM_HIGH   = 19;
  localparam int POS_W       = 5;

  localparam logic [7:0] STOP_BYTE     = 8'hFF;
  localparam logic [8:0] FLETCHER_MOD  = 9'd255;
  localparam logic [7:0] MIN_POLES     = 8'd2;

  // Duty / 100 as (duty >> 2) * ceil(2^19 / 25) >> 19, exact for 16-bit duty
  localparam logic [14:0] DUTY_RECIP = 15'd20972;
  localparam int          DUTY_SHIFT = 19;

  // Divider iteration count
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int ERR_CNT_BITS_DEF = 16;

  // Register file
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    STAT_GOOD     = 2'd0,
    STAT_STOP_ERR = 2'd1,
    STAT_CSUM_ERR = 2'd2
  } frame_status_t;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_DIVIDE,
    RS_HOLD
  } res_state_t;

  typedef enum logic [1:0] {
    REG_POLE_COUNT  = 2'd0,
    REG_BATT_MIN    = 2'd1,
    REG_VOLT_OFFSET = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic             take;
    logic             restart;
    logic [POS_W-1:0] pos;
    logic             finish;
    logic             div_step;
    logic             load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_good;
  } dp_sts_t;

  typedef struct packed {
    logic [7:0]  pole_count;
    logic [15:0] batt_min;
    logic [9:0]  volt_offset;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/telemetry_frame_checker_unit.sv -----
// Accepts one telemetry byte per cycle while in_stall is low; a frame is 22 bytes.
// A bad frame's result goes straight to the hold state when its last byte is taken, a good
// frame's after the 32-step restoring divider for rpm / pole count; it then loads as output.
// The next frame is collected while the divider runs; only its last byte waits.
// Synchronous active-low reset clears the frame tracker, sums, error counters and
// output valid, and loads the register reset values; the frame store is not cleared.
`default_nettype none

module telemetry_frame_checker_unit
  import tfc_pkg::*;
#(
  parameter int ERROR_COUNT_BITS = ERR_CNT_BITS_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_frame_start,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_frame_status,
  output logic [16:0]                out_volts_centi,
  output logic [15:0]                out_temperature_raw,
  output logic signed [15:0]         out_current_raw,
  output logic [30:0]                out_motor_rpm,
  output logic [9:0]                 out_duty_in_pct,
  output logic [9:0]                 out_duty_out_pct,
  output logic [7:0]                 out_status_bits,
  output logic [15:0]                out_stop_error_count,
  output logic [15:0]                out_checksum_error_count,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  tfc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tfc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_frame_start (in_frame_start),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  tfc_dp #(
    .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .cfg                      (cfg),
    .in_data_byte             (in_data_byte),
    .sts                      (sts),
    .out_frame_status         (out_frame_status),
    .out_volts_centi          (out_volts_centi),
    .out_temperature_raw      (out_temperature_raw),
    .out_current_raw          (out_current_raw),
    .out_motor_rpm            (out_motor_rpm),
    .out_duty_in_pct          (out_duty_in_pct),
    .out_duty_out_pct         (out_duty_out_pct),
    .out_status_bits          (out_status_bits),
    .out_stop_error_count     (out_stop_error_count),
    .out_checksum_error_count (out_checksum_error_count)
  );

endmodule

`default_nettype wire

// ----- hdl/tfc_regs.sv -----
`default_nettype none

module tfc_regs
  import tfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  reg_index_t idx;
  logic       wr_en;

  assign idx        = reg_index_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pole_count  <= 8'd62;
      cfg_r.batt_min    <= 16'd6000;
      cfg_r.volt_offset <= 10'd150;
    end else if (wr_en) begin
      case (idx)
        REG_POLE_COUNT:  cfg_r.pole_count  <= cfg_pwdata[7:0];
        REG_BATT_MIN:    cfg_r.batt_min    <= cfg_pwdata[15:0];
        REG_VOLT_OFFSET: cfg_r.volt_offset <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_POLE_COUNT:  cfg_prdata = CFG_DATA_W'(cfg_r.pole_count);
      REG_BATT_MIN:    cfg_prdata = CFG_DATA_W'(cfg_r.batt_min);
      REG_VOLT_OFFSET: cfg_prdata = CFG_DATA_W'(cfg_r.volt_offset);
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/tfc_ctrl.sv -----
`default_nettype none

module tfc_ctrl
  import tfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_frame_start,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  dp_sts_t   sts,
  output dp_cmd_t   cmd
);

  res_state_t           res_r, res_nxt;
  logic                 collecting_r, collecting_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic             accept;
  logic             take;
  logic             last;
  logic             load;
  logic             div_last;
  logic [POS_W-1:0] eff_pos;

  // Hold the final byte of a frame while the previous result is still in flight
  assign in_stall = collecting_r && (pos_r == POS_W'(FRAME_LAST)) && (res_r != RS_IDLE);
  assign accept   = in_valid && !in_stall;
  assign take     = accept && (in_frame_start || collecting_r);
  assign eff_pos  = in_frame_start ? '0 : pos_r;
  assign last     = take && (eff_pos == POS_W'(FRAME_LAST));
  assign load     = (res_r == RS_HOLD) && (!out_valid_r || !out_stall);
  assign div_last = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign out_valid = out_valid_r;

  // Track byte position within the frame
  always_comb begin
    collecting_nxt = collecting_r;
    pos_nxt        = pos_r;
    if (take) begin
      if (last) begin
        collecting_nxt = 1'b0;
        pos_nxt        = '0;
      end else begin
        collecting_nxt = 1'b1;
        pos_nxt        = eff_pos + 1'b1;
      end
    end
  end

  // Result sequencer: next state
  always_comb begin
    res_nxt = res_r;
    case (res_r)
      RS_IDLE: begin
        if (last) begin
          res_nxt = sts.frame_good ? RS_DIVIDE : RS_HOLD;
        end
      end
      RS_DIVIDE: begin
        if (div_last) begin
          res_nxt = RS_HOLD;
        end
      end
      RS_HOLD: begin
        if (load) begin
          res_nxt = RS_IDLE;
        end
      end
      default: res_nxt = RS_IDLE;
    endcase
  end

  // Result sequencer: commands
  always_comb begin
    cmd.take      = take;
    cmd.restart   = take && in_frame_start;
    cmd.pos       = eff_pos;
    cmd.finish    = last;
    cmd.div_step  = 1'b0;
    cmd.load_out  = 1'b0;
    div_cnt_nxt   = '0;
    case (res_r)
      RS_IDLE: ;
      RS_DIVIDE: begin
        cmd.div_step  = 1'b1;
        div_cnt_nxt   = div_cnt_r + 1'b1;
      end
      RS_HOLD: begin
        cmd.load_out = load;
      end
      default: ;
    endcase
  end

  // Output word valid: set on load, drop once taken
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r        <= RS_IDLE;
      collecting_r <= 1'b0;
      pos_r        <= '0;
      div_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      res_r        <= res_nxt;
      collecting_r <= collecting_nxt;
      pos_r        <= pos_nxt;
      div_cnt_r    <= div_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tfc_dp.sv -----
`default_nettype none

module tfc_dp
  import tfc_pkg::*;
#(
  parameter int ERROR_COUNT_BITS = ERR_CNT_BITS_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  dp_cmd_t          cmd,
  input  cfg_t             cfg,
  input  wire logic [7:0]  in_data_byte,
  output dp_sts_t          sts,
  output logic [1:0]       out_frame_status,
  output logic [16:0]      out_volts_centi,
  output logic [15:0]      out_temperature_raw,
  output logic signed [15:0] out_current_raw,
  output logic [30:0]      out_motor_rpm,
  output logic [9:0]       out_duty_in_pct,
  output logic [9:0]       out_duty_out_pct,
  output logic [7:0]       out_status_bits,
  output logic [15:0]      out_stop_error_count,
  output logic [15:0]      out_checksum_error_count
);

  // Frame bytes 0..19 as a shift line; byte k ends in entry k
  logic [7:0] store_r [STORE_BYTES];

  logic [7:0] low_r, high_r;
  logic       stop1_ok_r;
  logic [ERROR_COUNT_BITS-1:0] stop_cnt_r, csum_cnt_r;

  // Pending decoded fields of the finished frame
  frame_status_t pend_status_r;
  logic [16:0]   pend_volts_r;
  logic [15:0]   pend_temp_r;
  logic [15:0]   pend_current_r;
  logic [9:0]    pend_din_r, pend_dout_r;
  logic [7:0]    pend_bits_r;

  // Rpm divider: quotient builds up in the dividend register
  logic [31:0] rpm_q_r;
  logic [7:0]  rpm_rem_r;
  logic [7:0]  poles_r;

  // Output registers
  frame_status_t out_status_r;
  logic [16:0]   out_volts_r;
  logic [15:0]   out_temp_r;
  logic [15:0]   out_current_r;
  logic [30:0]   out_rpm_r;
  logic [9:0]    out_din_r, out_dout_r;
  logic [7:0]    out_bits_r;
  logic [15:0]   out_stop_cnt_r, out_csum_cnt_r;

  logic [7:0]  low_base, high_base, low_mod, high_mod;
  logic [8:0]  low_sum, high_sum;
  logic        stop_ok, sum_ok, good;
  logic [15:0] volts_raw;
  logic [7:0]  poles_eff;
  logic [8:0]  rpm_trial;
  logic        rpm_qbit;
  logic [13:0] din_quarter, dout_quarter;
  logic [28:0] din_prod, dout_prod;

  // Fletcher-16 running sums, each reduced mod 255 by one compare and subtract
  assign low_base  = cmd.restart ? '0 : low_r;
  assign high_base = cmd.restart ? '0 : high_r;
  assign low_sum   = {1'b0, low_base} + {1'b0, in_data_byte};
  assign low_mod   = (low_sum >= FLETCHER_MOD) ? 8'(low_sum - FLETCHER_MOD) : low_sum[7:0];
  assign high_sum  = {1'b0, high_base} + {1'b0, low_mod};
  assign high_mod  = (high_sum >= FLETCHER_MOD) ? 8'(high_sum - FLETCHER_MOD) : high_sum[7:0];

  // Judge the frame on its last byte
  assign stop_ok = stop1_ok_r && (in_data_byte == STOP_BYTE);
  assign sum_ok  = (low_r == store_r[CSUM_LOW]) && (high_r == store_r[CSUM_HIGH]);
  assign good    = stop_ok && sum_ok;
  assign sts.frame_good = good;

  assign volts_raw = {store_r[1], store_r[0]};
  assign poles_eff = (cfg.pole_count < MIN_POLES) ? MIN_POLES : cfg.pole_count;

  // Duty / 100 by reciprocal multiplication of duty / 4
  assign din_quarter  = {store_r[13], store_r[12][7:2]};
  assign dout_quarter = {store_r[15], store_r[14][7:2]};
  assign din_prod     = 29'(din_quarter) * 29'(DUTY_RECIP);
  assign dout_prod    = 29'(dout_quarter) * 29'(DUTY_RECIP);

  // One restoring division step
  assign rpm_trial  = {rpm_rem_r, rpm_q_r[31]};
  assign rpm_qbit   = rpm_trial >= {1'b0, poles_r};

  // Collect bytes and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r      <= '0;
      high_r     <= '0;
      stop1_ok_r <= 1'b0;
    end else if (cmd.take) begin
      if (cmd.pos < POS_W'(SUM_BYTES)) begin
        low_r  <= low_mod;
        high_r <= high_mod;
      end
      if (cmd.pos == POS_W'(STOP1_POS)) begin
        stop1_ok_r <= in_data_byte == STOP_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && (cmd.pos < POS_W'(STORE_BYTES))) begin
      for (int i = 0; i < STORE_BYTES - 1; i++) begin
        store_r[i] <= store_r[i + 1];
      end
      store_r[STORE_BYTES - 1] <= in_data_byte;
    end
  end

  // Saturating error counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_cnt_r <= '0;
      csum_cnt_r <= '0;
    end else if (cmd.finish) begin
      if (!stop_ok) begin
        if (stop_cnt_r != '1) begin
          stop_cnt_r <= stop_cnt_r + 1'b1;
        end
      end else if (!sum_ok) begin
        if (csum_cnt_r != '1) begin
          csum_cnt_r <= csum_cnt_r + 1'b1;
        end
      end
    end
  end

  // Latch decoded fields and divider operands; on a bad frame zero all but the status
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rpm_rem_r  <= '0;
      poles_r    <= poles_eff;
      if (good) begin
        pend_status_r  <= STAT_GOOD;
        pend_volts_r   <= (volts_raw > cfg.batt_min) ?
                          17'(volts_raw) + 17'(cfg.volt_offset) : 17'(volts_raw);
        pend_temp_r    <= {store_r[3], store_r[2]};
        pend_current_r <= {store_r[5], store_r[4]};
        pend_din_r     <= din_prod[DUTY_SHIFT +: 10];
        pend_dout_r    <= dout_prod[DUTY_SHIFT +: 10];
        pend_bits_r    <= store_r[16];
        rpm_q_r        <= {store_r[11], store_r[10], store_r[9], store_r[8]};
      end else begin
        pend_status_r  <= stop_ok ? STAT_CSUM_ERR : STAT_STOP_ERR;
        pend_volts_r   <= '0;
        pend_temp_r    <= '0;
        pend_current_r <= '0;
        pend_din_r     <= '0;
        pend_dout_r    <= '0;
        pend_bits_r    <= '0;
        rpm_q_r        <= '0;
      end
    end else if (cmd.div_step) begin
      rpm_rem_r <= rpm_qbit ? 8'(rpm_trial - {1'b0, poles_r}) : rpm_trial[7:0];
      rpm_q_r   <= {rpm_q_r[30:0], rpm_qbit};
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r   <= pend_status_r;
      out_volts_r    <= pend_volts_r;
      out_temp_r     <= pend_temp_r;
      out_current_r  <= pend_current_r;
      out_rpm_r      <= rpm_q_r[30:0];
      out_din_r      <= pend_din_r;
      out_dout_r     <= pend_dout_r;
      out_bits_r     <= pend_bits_r;
      out_stop_cnt_r <= 16'(stop_cnt_r);
      out_csum_cnt_r <= 16'(csum_cnt_r);
    end
  end

  assign out_frame_status         = out_status_r;
  assign out_volts_centi          = out_volts_r;
  assign out_temperature_raw      = out_temp_r;
  assign out_current_raw          = $signed(out_current_r);
  assign out_motor_rpm            = out_rpm_r;
  assign out_duty_in_pct          = out_din_r;
  assign out_duty_out_pct         = out_dout_r;
  assign out_status_bits          = out_bits_r;
  assign out_stop_error_count     = out_stop_cnt_r;
  assign out_checksum_error_count = out_csum_cnt_r;

endmodule

`default_nettype wire
